// ----- rtl/cdsd_pkg.sv -----
// ----------------------------------------------------------------------------
// cdsd_pkg: shared types and constants of the civil date arithmetic unit
// Beat layouts, calendar constants, reciprocal multipliers for the constant
// divisions, and the month start tables.
// ----------------------------------------------------------------------------
package cdsd_pkg;

	localparam int YEAR_W  = 16;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int OFF_W   = 26;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 56;

	localparam int YEAR_LIMIT   = 32767;
	localparam int DAYS_PER_ERA = 146097;

	// years are biased by whole eras so the leap count works on positive values
	localparam int YEAR_BIAS  = 32800;
	// serials are biased by whole eras (less one for the 1-based day) before the inverse
	localparam int SHIFT_ERAS = 320;
	localparam int ZZ_BIAS    = (SHIFT_ERAS - YEAR_BIAS / 400) * DAYS_PER_ERA - 1;
	localparam int YEAR_BASE  = SHIFT_ERAS * 400;

	// floor(x / d) == (x * R) >> S whenever x * d < 2**S
	localparam int R25_SH    = 19;
	localparam longint unsigned R25    = ((64'd1 << R25_SH) + 64'd24) / 64'd25;
	localparam int ERA_SH    = 45;
	localparam longint unsigned R_ERA  =
		((64'd1 << ERA_SH) + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA);
	localparam int R1460_SH  = 29;
	localparam longint unsigned R1460  = ((64'd1 << R1460_SH) + 64'd1459) / 64'd1460;
	localparam int R36524_SH = 34;
	localparam longint unsigned R36524 = ((64'd1 << R36524_SH) + 64'd36523) / 64'd36524;
	localparam int R365_SH   = 27;
	localparam longint unsigned R365   = ((64'd1 << R365_SH) + 64'd364) / 64'd365;
	localparam int R153_SH   = 19;
	localparam longint unsigned R153   = ((64'd1 << R153_SH) + 64'd152) / 64'd153;

	typedef enum logic {
		KIND_SHIFT = 1'b0,
		KIND_DIFF  = 1'b1
	} kind_t;

	// last declared field in the lowest bits
	typedef struct packed {
		logic [3:0]         pad;
		logic [OFF_W-1:0]   offset_days;
		logic [DAY_W-1:0]   day_b;
		logic [MONTH_W-1:0] month_b;
		logic [YEAR_W-1:0]  year_b;
		logic [DAY_W-1:0]   day_a;
		logic [MONTH_W-1:0] month_a;
		logic [YEAR_W-1:0]  year_a;
	} in_beat_t;

	typedef struct packed {
		logic [4:0]         pad;
		logic [OFF_W-1:0]   day_difference;
		logic [DAY_W-1:0]   out_day;
		logic [MONTH_W-1:0] out_month;
		logic [YEAR_W-1:0]  out_year;
	} out_beat_t;

	// day of the March-based year on which a calendar month starts
	function automatic logic [8:0] doy_of_month(input logic [MONTH_W-1:0] month);
		logic [8:0] doy;
		case (month)
			4'd1:    doy = 9'd306;
			4'd2:    doy = 9'd337;
			4'd3:    doy = 9'd0;
			4'd4:    doy = 9'd31;
			4'd5:    doy = 9'd61;
			4'd6:    doy = 9'd92;
			4'd7:    doy = 9'd122;
			4'd8:    doy = 9'd153;
			4'd9:    doy = 9'd184;
			4'd10:   doy = 9'd214;
			4'd11:   doy = 9'd245;
			4'd12:   doy = 9'd275;
			default: doy = 9'd0;
		endcase
		return doy;
	endfunction

	// same table indexed by March-based month 0..11
	function automatic logic [8:0] doy_of_mp(input logic [3:0] mp);
		logic [8:0] doy;
		case (mp)
			4'd0:    doy = 9'd0;
			4'd1:    doy = 9'd31;
			4'd2:    doy = 9'd61;
			4'd3:    doy = 9'd92;
			4'd4:    doy = 9'd122;
			4'd5:    doy = 9'd153;
			4'd6:    doy = 9'd184;
			4'd7:    doy = 9'd214;
			4'd8:    doy = 9'd245;
			4'd9:    doy = 9'd275;
			4'd10:   doy = 9'd306;
			4'd11:   doy = 9'd337;
			default: doy = 9'd0;
		endcase
		return doy;
	endfunction

endpackage

// ----- rtl/civil_date_shift_and_difference_top.sv -----
// ----------------------------------------------------------------------------
// civil_date_shift_and_difference_top: proleptic Gregorian date arithmetic
// Shifts date A by a signed day count, or counts the days from date A to
// date B, through a day serial and a twelve stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                                         tuser
//  s_axis   in   year_a month_a day_a year_b month_b day_b     kind
//                offset_days
//  m_axis   out  out_year out_month out_day day_difference     invalid
//
// One beat enters per cycle while s_axis_tready is high.
// Most stages serve the reciprocal multiply chain of the serial to
// date conversion (era, century, year, month); each product is registered.
// Reset clears the stage valid bits only.
// A stall on m_axis freezes every stage together; s_axis_tready drops only
// while a result waits in the output register.

module civil_date_shift_and_difference_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// year_a[15:0] month_a[19:16] day_a[24:20] year_b[40:25] month_b[44:41]
	// day_b[49:45] offset_days[75:50], zero fill [79:76]
	input  logic [cdsd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// kind[0]
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_year[15:0] out_month[19:16] out_day[24:20] day_difference[50:25],
	// zero fill [55:51]
	output logic [cdsd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// invalid[0]
	output logic                             m_axis_tuser
);

	localparam int OW = cdsd_pkg::OFF_W;

	cdsd_pkg::in_beat_t  in_b;
	cdsd_pkg::out_beat_t out_s12;
	logic                en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;

	assign in_b          = cdsd_pkg::in_beat_t'(s_axis_tdata);
	assign en            = !vld_s12 || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s1  <= s_axis_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	// ---------------- stage 1: range checks, year bias, month start ----------
	logic        ma_ok, mb_ok, ya_ok, yb_ok, bad_w;
	logic [17:0] ybias_a_w, ybias_b_w;

	assign ma_ok = (in_b.month_a >= 4'd1) && (in_b.month_a <= 4'd12);
	assign mb_ok = (in_b.month_b >= 4'd1) && (in_b.month_b <= 4'd12);
	assign ya_ok = in_b.year_a != 16'h8000;
	assign yb_ok = in_b.year_b != 16'h8000;
	assign bad_w = !(ma_ok && ya_ok) ||
		((s_axis_tuser == cdsd_pkg::KIND_DIFF) && !(mb_ok && yb_ok));

	// January and February count with the previous year
	assign ybias_a_w = {{2{in_b.year_a[15]}}, in_b.year_a} + 18'(cdsd_pkg::YEAR_BIAS)
		- 18'(in_b.month_a <= 4'd2);
	assign ybias_b_w = {{2{in_b.year_b[15]}}, in_b.year_b} + 18'(cdsd_pkg::YEAR_BIAS)
		- 18'(in_b.month_b <= 4'd2);

	logic          kind_s1, bad_s1;
	logic [OW-1:0] off_s1;
	logic [16:0]   ya_s1, yb_s1;
	logic [8:0]    dda_s1, ddb_s1;

	// ---------------- stage 2: leap count and year length products ---------
	logic          kind_s2, bad_s2;
	logic [OW-1:0] off_s2;
	logic [14:0]   ya4_s2, yb4_s2;
	logic [29:0]   p100a_s2, p100b_s2;
	logic [27:0]   p400a_s2, p400b_s2;
	logic [24:0]   p365a_s2, p365b_s2;
	logic [8:0]    dda_s2, ddb_s2;

	// ---------------- stage 3: biased day counts ----------------------------
	logic          kind_s3, bad_s3;
	logic [OW-1:0] off_s3;
	logic [24:0]   days_a_s3, days_b_s3;

	// ---------------- stage 4: shifted serial and difference ----------------
	logic [27:0]   zz_w;
	logic          kind_s4, bad_s4;
	logic [26:0]   zz_s4;
	logic [OW-1:0] diff_s4;

	assign zz_w = {3'b000, days_a_s3} + {{2{off_s3[OW-1]}}, off_s3}
		+ 28'(cdsd_pkg::ZZ_BIAS);

	// ---------------- stage 5: era product ----------------------------------
	logic          kind_s5, bad_s5;
	logic [26:0]   zz_s5;
	logic [54:0]   pera_s5;
	logic [OW-1:0] diff_s5;

	// ---------------- stage 6: era and day of era ---------------------------
	logic [9:0]    era_w;
	logic [26:0]   doe_w;
	logic          kind_s6, bad_s6;
	logic [9:0]    era_s6;
	logic [17:0]   doe_s6;
	logic [OW-1:0] diff_s6;

	assign era_w = pera_s5[cdsd_pkg::ERA_SH +: 10];
	assign doe_w = zz_s5 - 27'(era_w) * 27'(cdsd_pkg::DAYS_PER_ERA);

	// ---------------- stage 7: leap correction products ---------------------
	logic          kind_s7, bad_s7, last_s7;
	logic [17:0]   doe_s7;
	logic [36:0]   p1460_s7, p36524_s7;
	logic [19:0]   ybase_s7;
	logic [OW-1:0] diff_s7;

	// ---------------- stage 8: leap-free day count --------------------------
	logic          kind_s8, bad_s8;
	logic [17:0]   t_s8, doe_s8;
	logic [19:0]   ybase_s8;
	logic [OW-1:0] diff_s8;

	// ---------------- stage 9: year of era product --------------------------
	logic          kind_s9, bad_s9;
	logic [36:0]   p365_s9;
	logic [17:0]   doe_s9;
	logic [19:0]   ybase_s9;
	logic [OW-1:0] diff_s9;

	// ---------------- stage 10: day of year ---------------------------------
	logic [8:0]    yoe_w;
	logic [1:0]    cent_w;
	logic [17:0]   ydays_w, doy_w;
	logic          kind_s10, bad_s10;
	logic [8:0]    yoe_s10, doy_s10;
	logic [19:0]   ybase_s10;
	logic [OW-1:0] diff_s10;

	assign yoe_w   = p365_s9[cdsd_pkg::R365_SH +: 9];
	assign cent_w  = (yoe_w >= 9'd300) ? 2'd3 :
		(yoe_w >= 9'd200) ? 2'd2 :
		(yoe_w >= 9'd100) ? 2'd1 : 2'd0;
	assign ydays_w = 18'(yoe_w) * 18'd365 + 18'(yoe_w[8:2]) - 18'(cent_w);
	assign doy_w   = doe_s9 - ydays_w;

	// ---------------- stage 11: month product -------------------------------
	logic [10:0]   mx_w;
	logic          kind_s11, bad_s11;
	logic [22:0]   p153_s11;
	logic [8:0]    yoe_s11, doy_s11;
	logic [19:0]   ybase_s11;
	logic [OW-1:0] diff_s11;

	assign mx_w = {doy_s10, 2'b00} + 11'(doy_s10) + 11'd2;

	// ---------------- stage 12: calendar date and output select -------------
	logic [3:0]               mp_w, month_w;
	logic [8:0]               dday_w;
	logic signed [19:0]       year_w;
	logic                     ybad_w, fail_w;
	cdsd_pkg::out_beat_t      out_w;

	assign mp_w    = p153_s11[cdsd_pkg::R153_SH +: 4];
	assign month_w = (mp_w < 4'd10) ? mp_w + 4'd3 : mp_w - 4'd9;
	assign dday_w  = doy_s11 - cdsd_pkg::doy_of_mp(mp_w) + 9'd1;
	assign year_w  = $signed(ybase_s11 + 20'(yoe_s11) + 20'(month_w <= 4'd2));
	assign ybad_w  = (year_w > 20'sd32767) || (year_w < -20'sd32767);
	assign fail_w  = bad_s11 || ((kind_s11 == cdsd_pkg::KIND_SHIFT) && ybad_w);

	always_comb begin
		out_w = '0;
		if (!fail_w) begin
			if (kind_s11 == cdsd_pkg::KIND_SHIFT) begin
				out_w.out_year  = year_w[15:0];
				out_w.out_month = month_w;
				out_w.out_day   = dday_w[4:0];
			end else begin
				out_w.day_difference = diff_s11;
			end
		end
	end

	logic inv_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			kind_s1 <= s_axis_tuser;
			bad_s1  <= bad_w;
			off_s1  <= in_b.offset_days;
			ya_s1   <= ybias_a_w[16:0];
			yb_s1   <= ybias_b_w[16:0];
			dda_s1  <= cdsd_pkg::doy_of_month(in_b.month_a) + 9'(in_b.day_a);
			ddb_s1  <= cdsd_pkg::doy_of_month(in_b.month_b) + 9'(in_b.day_b);
			// stage 2
			kind_s2  <= kind_s1;
			bad_s2   <= bad_s1;
			off_s2   <= off_s1;
			ya4_s2   <= ya_s1[16:2];
			yb4_s2   <= yb_s1[16:2];
			p100a_s2 <= 30'(ya_s1[16:2]) * 30'(cdsd_pkg::R25);
			p100b_s2 <= 30'(yb_s1[16:2]) * 30'(cdsd_pkg::R25);
			p400a_s2 <= 28'(ya_s1[16:4]) * 28'(cdsd_pkg::R25);
			p400b_s2 <= 28'(yb_s1[16:4]) * 28'(cdsd_pkg::R25);
			p365a_s2 <= 25'(ya_s1) * 25'd365;
			p365b_s2 <= 25'(yb_s1) * 25'd365;
			dda_s2   <= dda_s1;
			ddb_s2   <= ddb_s1;
			// stage 3
			kind_s3   <= kind_s2;
			bad_s3    <= bad_s2;
			off_s3    <= off_s2;
			days_a_s3 <= p365a_s2 + 25'(ya4_s2) - 25'(p100a_s2[29:cdsd_pkg::R25_SH])
				+ 25'(p400a_s2[27:cdsd_pkg::R25_SH]) + 25'(dda_s2);
			days_b_s3 <= p365b_s2 + 25'(yb4_s2) - 25'(p100b_s2[29:cdsd_pkg::R25_SH])
				+ 25'(p400b_s2[27:cdsd_pkg::R25_SH]) + 25'(ddb_s2);
			// stage 4: the bias cancels in the difference
			kind_s4 <= kind_s3;
			bad_s4  <= bad_s3;
			zz_s4   <= zz_w[26:0];
			diff_s4 <= {1'b0, days_b_s3} - {1'b0, days_a_s3};
			// stage 5
			kind_s5 <= kind_s4;
			bad_s5  <= bad_s4;
			zz_s5   <= zz_s4;
			pera_s5 <= 55'(zz_s4) * 55'(cdsd_pkg::R_ERA);
			diff_s5 <= diff_s4;
			// stage 6
			kind_s6 <= kind_s5;
			bad_s6  <= bad_s5;
			era_s6  <= era_w;
			doe_s6  <= doe_w[17:0];
			diff_s6 <= diff_s5;
			// stage 7
			kind_s7   <= kind_s6;
			bad_s7    <= bad_s6;
			doe_s7    <= doe_s6;
			p1460_s7  <= 37'(doe_s6) * 37'(cdsd_pkg::R1460);
			p36524_s7 <= 37'(doe_s6) * 37'(cdsd_pkg::R36524);
			last_s7   <= doe_s6 == 18'(cdsd_pkg::DAYS_PER_ERA - 1);
			ybase_s7  <= 20'(era_s6) * 20'd400 - 20'(cdsd_pkg::YEAR_BASE);
			diff_s7   <= diff_s6;
			// stage 8
			kind_s8  <= kind_s7;
			bad_s8   <= bad_s7;
			t_s8     <= doe_s7 - 18'(p1460_s7[36:cdsd_pkg::R1460_SH])
				+ 18'(p36524_s7[36:cdsd_pkg::R36524_SH]) - 18'(last_s7);
			doe_s8   <= doe_s7;
			ybase_s8 <= ybase_s7;
			diff_s8  <= diff_s7;
			// stage 9
			kind_s9  <= kind_s8;
			bad_s9   <= bad_s8;
			p365_s9  <= 37'(t_s8) * 37'(cdsd_pkg::R365);
			doe_s9   <= doe_s8;
			ybase_s9 <= ybase_s8;
			diff_s9  <= diff_s8;
			// stage 10
			kind_s10  <= kind_s9;
			bad_s10   <= bad_s9;
			yoe_s10   <= yoe_w;
			doy_s10   <= doy_w[8:0];
			ybase_s10 <= ybase_s9;
			diff_s10  <= diff_s9;
			// stage 11
			kind_s11  <= kind_s10;
			bad_s11   <= bad_s10;
			p153_s11  <= 23'(mx_w) * 23'(cdsd_pkg::R153);
			yoe_s11   <= yoe_s10;
			doy_s11   <= doy_s10;
			ybase_s11 <= ybase_s10;
			diff_s11  <= diff_s10;
			// stage 12
			out_s12 <= out_w;
			inv_s12 <= fail_w;
		end
	end

	assign m_axis_tvalid = vld_s12;
	assign m_axis_tdata  = out_s12;
	assign m_axis_tuser  = inv_s12;

endmodule

// ----- rtl/cdsd_checker.sv -----
// ----------------------------------------------------------------------------
// cdsd_checker: port-level checks of the civil date arithmetic unit
// Watches the stream ports of the top level; attached by the bind below.
// ----------------------------------------------------------------------------
module cdsd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [cdsd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic                            s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [cdsd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tuser
);

	cdsd_pkg::out_beat_t ob;

	assign ob = cdsd_pkg::out_beat_t'(m_axis_tdata);

	// hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// an invalid result carries no date and no difference
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("invalid result with nonzero data");

	// a shifted date is a full calendar date and leaves the difference empty
	a_shift_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser && (ob.out_month != 4'd0) |->
		(ob.out_month <= 4'd12) && (ob.out_day != 5'd0) && (ob.day_difference == '0))
		else $error("malformed shift result");

	// never refuse input while the output register is empty
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input refused with empty output");

endmodule

bind civil_date_shift_and_difference_top cdsd_checker u_cdsd_checker (.*);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the civil date shift and difference unit
// Drives shift and difference requests on the input stream with random gaps,
// stalls the result stream at random (once for a long stretch), predicts
// every result in a scoreboard and compares each result beat field by field.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cdsd_pkg::*;

	localparam longint EPOCH_DAYS  = 719468;
	localparam int     STALL_LIMIT = 4000;
	localparam int     DRAIN_CYCLES = 40;
	localparam int     RANDOM_ITEMS = 1530;
	localparam int     LONG_HOLD    = 250;
	localparam int     HOLD_AT      = 400;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [OFF_W-1:0]   diff;
		logic               inv;
	} date_result_t;

	class date_scoreboard;
		date_result_t pending_results[$];
		int           mismatch_count;

		function new();
			mismatch_count = 0;
		endfunction

		function longint floor_quot(longint num, longint den);
			if (num >= 0)
				return num / den;
			return (num - (den - 1)) / den;
		endfunction

		// day serial of the first of month m in year y, 1970-01-01 = 0
		function longint month_start_serial(longint y, longint m);
			longint ys, era, yoe, mp, doy, doe;
			ys  = (m <= 2) ? y - 1 : y;
			era = floor_quot(ys, 400);
			yoe = ys - era * 400;
			mp  = (m > 2) ? m - 3 : m + 9;
			doy = (153 * mp + 2) / 5;
			doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
			return era * DAYS_PER_ERA + doe - EPOCH_DAYS;
		endfunction

		function bit date_to_serial(longint y, longint m, longint d, output longint s);
			s = 0;
			if (m < 1 || m > 12 || y < -YEAR_LIMIT || y > YEAR_LIMIT)
				return 1'b0;
			s = month_start_serial(y, m) + d - 1;
			return 1'b1;
		endfunction

		function void serial_to_civil(longint z, output longint y, output longint m,
				output longint d);
			longint zz, era, doe, yoe, doy, mp;
			zz  = z + EPOCH_DAYS;
			era = floor_quot(zz, DAYS_PER_ERA);
			doe = zz - era * DAYS_PER_ERA;
			yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
			doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
			mp  = (5 * doy + 2) / 153;
			d   = doy - (153 * mp + 2) / 5 + 1;
			m   = (mp < 10) ? mp + 3 : mp - 9;
			y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
		endfunction

		function date_result_t predict_date(logic kind, in_beat_t b);
			date_result_t r;
			longint ya, yb, off, sa, sb, y, m, d;
			bit ok;
			r  = '0;
			ya = $signed(b.year_a);
			ok = date_to_serial(ya, longint'(b.month_a), longint'(b.day_a), sa);
			if (kind == KIND_SHIFT) begin
				if (ok) begin
					off = $signed(b.offset_days);
					serial_to_civil(sa + off, y, m, d);
					if (y < -YEAR_LIMIT || y > YEAR_LIMIT)
						ok = 1'b0;
					r.year  = YEAR_W'(y);
					r.month = MONTH_W'(m);
					r.day   = DAY_W'(d);
				end
			end else begin
				yb = $signed(b.year_b);
				if (!date_to_serial(yb, longint'(b.month_b), longint'(b.day_b), sb))
					ok = 1'b0;
				r.diff = OFF_W'(sb - sa);
			end
			if (!ok) begin
				r     = '0;
				r.inv = 1'b1;
			end
			return r;
		endfunction

		function void note_request(logic kind, logic [IN_DATA_W-1:0] data);
			pending_results.push_back(predict_date(kind, in_beat_t'(data)));
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
				mismatch_count++;
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data, logic user);
			out_beat_t    got;
			date_result_t want;
			got = data;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result beat: expected none actual %h/%b",
					$time, data, user);
				mismatch_count++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("out_year", $signed(want.year), $signed(got.out_year));
			compare_field("out_month", want.month, got.out_month);
			compare_field("out_day", want.day, got.out_day);
			compare_field("day_difference", $signed(want.diff), $signed(got.day_difference));
			compare_field("invalid", want.inv, user);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	date_scoreboard sb = new();
	int gap_mode = 0;

	civil_date_shift_and_difference_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// 0: full random gaps, 1: back to back, 2: mostly back to back
	function int pick_gap();
		case (gap_mode)
			1:       return 0;
			2:       return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 16)) : 0;
			default: return int'($urandom_range(0, 16));
		endcase
	endfunction

	function int random_year();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 1970 + int'($urandom_range(0, 1000)) - 500;
			4, 5:       return int'($signed(16'($urandom())));
			6:          return YEAR_LIMIT - int'($urandom_range(0, 2));
			7:          return -YEAR_LIMIT + int'($urandom_range(0, 2));
			default:    return int'($urandom_range(0, 65534)) - YEAR_LIMIT;
		endcase
	endfunction

	function int random_month();
		if ($urandom_range(0, 9) == 0)
			return int'($urandom_range(0, 15));
		return int'($urandom_range(1, 12));
	endfunction

	function int random_offset();
		case ($urandom_range(0, 5))
			0, 1:    return int'($urandom_range(0, 800)) - 400;
			2:       return int'($urandom_range(0, 2000000)) - 1000000;
			3:       return int'($urandom_range(0, 48000000)) - 24000000;
			4:       return int'($signed(26'($urandom())));
			default: begin
				case ($urandom_range(0, 2))
					0:       return -33554432;
					1:       return 33554431;
					default: return 0;
				endcase
			end
		endcase
	endfunction

	task automatic push_request(logic kind, int ya, int ma, int da, int yb, int mb,
			int db, int off);
		in_beat_t b;
		int       gap;
		b.pad         = '0;
		b.year_a      = YEAR_W'(ya);
		b.month_a     = MONTH_W'(ma);
		b.day_a       = DAY_W'(da);
		b.year_b      = YEAR_W'(yb);
		b.month_b     = MONTH_W'(mb);
		b.day_b       = DAY_W'(db);
		b.offset_days = OFF_W'(off);
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// result side: random stall per beat, one long hold to back the pipe up
	initial begin
		int  results_seen;
		bit  held;
		results_seen = 0;
		held = 1'b0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			int n;
			n = pick_gap();
			if (results_seen == HOLD_AT && !held) begin
				n = LONG_HOLD;
				held = 1'b1;
			end
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_request(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[civil_date_shift_and_difference_top] ERROR");
		$finish;
	end

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= KIND_SHIFT;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain shifts, leap days and day-of-month rollover
		push_request(KIND_SHIFT, 1970, 1, 1, 0, 0, 0, 0);
		push_request(KIND_SHIFT, 2000, 2, 28, 0, 0, 0, 1);
		push_request(KIND_SHIFT, 1900, 2, 29, 0, 0, 0, 0);
		push_request(KIND_SHIFT, 2024, 1, 0, 0, 0, 0, 0);
		push_request(KIND_SHIFT, 2023, 2, 31, 0, 0, 0, 0);
		// year range edges and result overflow
		push_request(KIND_SHIFT, YEAR_LIMIT, 12, 31, 0, 0, 0, 0);
		push_request(KIND_SHIFT, YEAR_LIMIT, 12, 31, 0, 0, 0, 1);
		push_request(KIND_SHIFT, -YEAR_LIMIT, 1, 1, 0, 0, 0, 0);
		push_request(KIND_SHIFT, -YEAR_LIMIT, 1, 1, 0, 0, 0, -1);
		push_request(KIND_SHIFT, -YEAR_LIMIT, 1, 1, 0, 0, 0, 23935000);
		push_request(KIND_SHIFT, 1970, 1, 1, 0, 0, 0, 33554431);
		push_request(KIND_SHIFT, 1970, 1, 1, 0, 0, 0, -33554432);
		// bad inputs on a shift; date B fields must be ignored
		push_request(KIND_SHIFT, -32768, 6, 15, 0, 0, 0, 0);
		push_request(KIND_SHIFT, 2001, 0, 10, 0, 0, 0, 5);
		push_request(KIND_SHIFT, 2001, 13, 10, 0, 0, 0, 5);
		push_request(KIND_SHIFT, 2001, 15, 10, 0, 0, 0, 5);
		push_request(KIND_SHIFT, 2001, 7, 4, -32768, 15, 31, 100);
		// differences: extremes, reversal, equal dates, invalid date B or A
		push_request(KIND_DIFF, -YEAR_LIMIT, 1, 1, YEAR_LIMIT, 12, 31, 0);
		push_request(KIND_DIFF, YEAR_LIMIT, 12, 31, -YEAR_LIMIT, 1, 1, -1);
		push_request(KIND_DIFF, 1999, 5, 17, 1999, 5, 17, 12345);
		push_request(KIND_DIFF, 2020, 3, 0, 2020, 2, 31, 0);
		push_request(KIND_DIFF, 2020, 3, 1, 2020, 0, 1, 0);
		push_request(KIND_DIFF, 2020, 3, 1, -32768, 3, 1, 0);
		push_request(KIND_DIFF, 2020, 14, 1, 2021, 3, 1, 0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0)
				gap_mode = int'($urandom_range(0, 2));
			push_request(1'($urandom_range(0, 1)), random_year(), random_month(),
				int'($urandom_range(0, 31)), random_year(), random_month(),
				int'($urandom_range(0, 31)), random_offset());
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
			$display("[civil_date_shift_and_difference_top] OK");
		else
			$display("[civil_date_shift_and_difference_top] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/cdsd_pkg.sv
rtl/civil_date_shift_and_difference_top.sv
rtl/cdsd_checker.sv
verif/tb_top.sv
